// ===== rtl/dmlp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dmlp_pkg
// types, constants and helper functions for the dense network inference block
// ----------------------------------------------------------------------------
package dmlp_pkg;

   localparam int MAX_LAYERS   = 4;
   localparam int MAX_WIDTH    = 16;
   localparam int VALUE_BITS   = 16;
   localparam int FRAC_BITS    = 12;
   localparam int LAYER_BITS   = 2;
   localparam int IDX_BITS     = 4;
   localparam int CNT_BITS     = 5;
   localparam int CFG_BITS     = 5;
   localparam int CSR_IDX_BITS = 3;
   localparam int WDEPTH       = (MAX_LAYERS - 1) * MAX_WIDTH * MAX_WIDTH;
   localparam int WADDR_BITS   = 10;
   localparam int ADEPTH       = MAX_LAYERS * MAX_WIDTH;
   localparam int AADDR_BITS   = 6;
   localparam int SIG_DEPTH    = 256;
   localparam int SIG_IDX_BITS = 8;

   localparam logic [CSR_IDX_BITS-1:0] CSR_LAYER_COUNT = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WIDTH0      = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WIDTH1      = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WIDTH2      = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WIDTH3      = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ACT_MODE    = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SQUASH_IN   = 3'd6;

   localparam logic KIND_WEIGHT = 1'b0;
   localparam logic KIND_ACT    = 1'b1;

   localparam logic MODE_SIGMOID = 1'b0;
   localparam logic MODE_LINEAR  = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_SRC,
      ST_WRD,
      ST_MUL,
      ST_ACC,
      ST_SQ,
      ST_OUT
   } state_type;

   // clamp a width register to 1..MAX_WIDTH
   function automatic logic [CNT_BITS-1:0] width_of(input logic [CFG_BITS-1:0] w);
      logic [CNT_BITS-1:0] r;
      if (w == '0) begin
         r = CNT_BITS'(1);
      end else if (w > CFG_BITS'(MAX_WIDTH)) begin
         r = CNT_BITS'(MAX_WIDTH);
      end else begin
         r = w;
      end
      return r;
   endfunction

   // clamp the layer count to 2..4
   function automatic logic [2:0] layers_used(input logic [2:0] lc);
      logic [2:0] r;
      if (lc < 3'd2) begin
         r = 3'd2;
      end else if (lc > 3'(MAX_LAYERS)) begin
         r = 3'(MAX_LAYERS);
      end else begin
         r = lc;
      end
      return r;
   endfunction

   // one sigmoid sample, evaluated at elaboration only
   function automatic logic [VALUE_BITS-1:0] sig_entry(input int unsigned i);
      longint      off;
      longint      x;
      logic [63:0] one;
      logic [63:0] t;
      logic [63:0] z;
      logic [63:0] z2;
      logic [63:0] z3;
      logic [63:0] z4;
      logic [63:0] e;
      logic [63:0] den;
      logic [63:0] num;
      logic [63:0] rem;
      logic [63:0] q;
      int          k;
      one = 64'd1 << 30;
      off = (longint'(2 * i + 1) * (longint'(16) << FRAC_BITS)) / (2 * SIG_DEPTH);
      x   = off - (longint'(8) << FRAC_BITS);
      t   = (x < 0) ? 64'(-x) : 64'(x);
      z   = (t << (30 - FRAC_BITS)) >> 8;
      z2  = (z * z) >> 30;
      z3  = (z2 * z) >> 30;
      z4  = (z3 * z) >> 30;
      e   = one - z + z2 / 2 - z3 / 6 + z4 / 24;
      for (k = 0; k < 8; k++) begin
         e = (e * e) >> 30;
      end
      den = one + e;
      num = (x >= 0) ? (one << FRAC_BITS) : (e << FRAC_BITS);
      num = num + (den >> 1);
      rem = '0;
      q   = '0;
      for (k = 63; k >= 0; k--) begin
         rem = {rem[62:0], num[k]};
         if (rem >= den) begin
            rem  = rem - den;
            q[k] = 1'b1;
         end
      end
      return q[VALUE_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/dense_mlp_forward_pass.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dense_mlp_forward_pass
// dense network inference in Q4.12 with one shared multiply-accumulate unit
// ----------------------------------------------------------------------------
// After reset the 768 weight store entries are swept to zero, during which
// no beat is taken (register writes still are). Weight and input beats are
// then taken one per cycle. A beat marked last on an input activation runs
// the pass on a single multiplier and adder under a small sequencer: per
// source it fetches the activation, then per destination reads the weight,
// multiplies and accumulates, through the one weight memory read port; then
// a hidden layer squashes each sum into the next layer's inputs, while the
// output layer squashes each sum into a result beat. The input channel is
// stalled from the last beat until the final result beat has been taken.
module dense_mlp_forward_pass
   import dmlp_pkg::*;
(
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire                           req_kind,
   input  wire  [1:0]                    req_weight_layer,
   input  wire  [IDX_BITS-1:0]           req_source_index,
   input  wire  [IDX_BITS-1:0]           req_dest_index,
   input  wire  signed [VALUE_BITS-1:0]  req_value,
   input  wire                           req_last,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic [IDX_BITS-1:0]           rsp_output_index,
   output logic signed [VALUE_BITS-1:0]  rsp_output_value,
   output logic                          rsp_output_last,
   input  wire                           csr_write,
   input  wire  [CSR_IDX_BITS-1:0]       csr_index,
   input  wire  [CFG_BITS-1:0]           csr_data
);

   state_type state_ff, state_in;

   logic [2:0]          layer_count_ff;
   logic [CFG_BITS-1:0] width_ff [MAX_LAYERS];
   logic                mode_ff;
   logic                sqin_ff;

   logic [WADDR_BITS-1:0] clr_ff, clr_in;
   logic [LAYER_BITS-1:0] l_ff, l_in;
   logic [IDX_BITS-1:0]   s_ff, s_in;
   logic [IDX_BITS-1:0]   d_ff, d_in;
   logic [MAX_WIDTH-1:0]  vld_ff;

   logic signed [VALUE_BITS-1:0] wmem [WDEPTH];
   logic signed [VALUE_BITS-1:0] amem [ADEPTH];
   logic signed [VALUE_BITS-1:0] w_q;
   logic signed [VALUE_BITS-1:0] a_q;
   logic                         a_vld_q;

   logic signed [VALUE_BITS-1:0]   src_ff;
   logic signed [2*VALUE_BITS-1:0] prod_ff;
   logic signed [VALUE_BITS-1:0]   acc_ff [MAX_WIDTH];

   logic                         rsp_valid_ff;
   logic [IDX_BITS-1:0]          rsp_index_ff;
   logic signed [VALUE_BITS-1:0] rsp_value_ff;
   logic                         rsp_last_ff;

   logic [VALUE_BITS-1:0] sig_rom [SIG_DEPTH];

   // control
   logic                  req_take;
   logic                  rsp_take;
   logic [2:0]            nl;
   logic [CNT_BITS-1:0]   ws;
   logic [CNT_BITS-1:0]   wd;
   logic [CNT_BITS-1:0]   w_in0;
   logic [CNT_BITS-1:0]   w_out;
   logic                  d_last;
   logic                  s_last;
   logic                  out_layer;
   logic                  w_we;
   logic [WADDR_BITS-1:0] w_waddr;
   logic signed [VALUE_BITS-1:0] w_wdata;
   logic                  a_we;
   logic [AADDR_BITS-1:0] a_waddr;
   logic signed [VALUE_BITS-1:0] a_wdata;
   logic                  vld_set;
   logic                  vld_clear;
   logic                  acc_clear;
   logic                  rsp_load;

   // datapath
   localparam logic signed [VALUE_BITS-1:0] SQ_HALF = VALUE_BITS'(1 << (FRAC_BITS - 1));
   localparam logic signed [VALUE_BITS+6:0] SUM_MAX =
      (VALUE_BITS+7)'((1 << (VALUE_BITS - 1)) - 1);
   localparam logic signed [VALUE_BITS+6:0] SUM_MIN = -(VALUE_BITS+7)'(1 << (VALUE_BITS - 1));

   logic signed [VALUE_BITS-1:0]   src_raw;
   logic signed [VALUE_BITS-1:0]   sq_in;
   logic signed [VALUE_BITS-1:0]   sq_out;
   logic [VALUE_BITS-1:0]          sq_biased;
   logic signed [VALUE_BITS:0]     lin2;
   logic signed [2*VALUE_BITS:0]   prod_rnd;
   logic signed [VALUE_BITS+4:0]   rnd;
   logic signed [VALUE_BITS+6:0]   sum;
   logic signed [VALUE_BITS-1:0]   sum_sat;

   for (genvar gi = 0; gi < SIG_DEPTH; gi++) begin : g_sig
      localparam logic [VALUE_BITS-1:0] SigVal = sig_entry(gi);
      assign sig_rom[gi] = SigVal;
   end

   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign nl        = layers_used(layer_count_ff);
   assign ws        = width_of(width_ff[l_ff]);
   assign wd        = width_of(width_ff[l_ff + LAYER_BITS'(1)]);
   assign w_in0     = width_of(width_ff[0]);
   assign w_out     = width_of(width_ff[LAYER_BITS'(nl - 3'd1)]);
   assign d_last    = ({1'b0, d_ff} == wd - CNT_BITS'(1));
   assign s_last    = ({1'b0, s_ff} == ws - CNT_BITS'(1));
   assign out_layer = ({1'b0, l_ff} == nl - 3'd2);

   // squash unit
   assign src_raw   = a_vld_q ? a_q : '0;
   assign sq_in     = (state_ff == ST_SRC) ? src_raw : acc_ff[d_ff];
   assign sq_biased = {~sq_in[VALUE_BITS-1], sq_in[VALUE_BITS-2:0]};
   assign lin2      = {sq_in, 1'b0} - (VALUE_BITS+1)'(1 << FRAC_BITS);

   always_comb begin
      if (mode_ff == MODE_LINEAR) begin
         if (sq_in > SQ_HALF) begin
            if (lin2 > (VALUE_BITS+1)'((1 << (VALUE_BITS - 1)) - 1)) begin
               sq_out = VALUE_BITS'((1 << (VALUE_BITS - 1)) - 1);
            end else begin
               sq_out = lin2[VALUE_BITS-1:0];
            end
         end else begin
            sq_out = '0;
         end
      end else begin
         sq_out = sig_rom[sq_biased[VALUE_BITS-1 -: SIG_IDX_BITS]];
      end
   end

   // rounding and saturating accumulate
   assign prod_rnd = {prod_ff[2*VALUE_BITS-1], prod_ff} + (2*VALUE_BITS+1)'(1 << (FRAC_BITS - 1));
   assign rnd      = prod_rnd[2*VALUE_BITS:FRAC_BITS];
   assign sum      = {{7{acc_ff[d_ff][VALUE_BITS-1]}}, acc_ff[d_ff]}
                     + {{2{rnd[VALUE_BITS+4]}}, rnd};

   always_comb begin
      if (sum > SUM_MAX) begin
         sum_sat = VALUE_BITS'((1 << (VALUE_BITS - 1)) - 1);
      end else if (sum < SUM_MIN) begin
         sum_sat = VALUE_BITS'(1 << (VALUE_BITS - 1));
      end else begin
         sum_sat = sum[VALUE_BITS-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == WADDR_BITS'(WDEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_take && req_kind == KIND_ACT && req_last) state_in = ST_FETCH;
         end
         ST_FETCH: state_in = ST_SRC;
         ST_SRC:   state_in = ST_WRD;
         ST_WRD:   state_in = ST_MUL;
         ST_MUL:   state_in = ST_ACC;
         ST_ACC: begin
            if (!d_last)     state_in = ST_WRD;
            else if (s_last) state_in = ST_SQ;
            else             state_in = ST_FETCH;
         end
         ST_SQ: begin
            if (out_layer)   state_in = ST_OUT;
            else if (d_last) state_in = ST_FETCH;
         end
         ST_OUT: begin
            if (rsp_take) state_in = d_last ? ST_IDLE : ST_SQ;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and counters
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      clr_in    = clr_ff;
      l_in      = l_ff;
      s_in      = s_ff;
      d_in      = d_ff;
      w_we      = 1'b0;
      w_waddr   = {l_ff, s_ff, d_ff};
      w_wdata   = req_value;
      a_we      = 1'b0;
      a_waddr   = {{(AADDR_BITS-IDX_BITS){1'b0}}, req_source_index};
      a_wdata   = req_value;
      vld_set   = 1'b0;
      vld_clear = 1'b0;
      acc_clear = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            w_we    = 1'b1;
            w_waddr = clr_ff;
            w_wdata = '0;
            clr_in  = clr_ff + WADDR_BITS'(1);
         end
         ST_IDLE: begin
            acc_clear = 1'b1;
            l_in      = '0;
            s_in      = '0;
            d_in      = '0;
            if (req_take && req_kind == KIND_WEIGHT &&
                req_weight_layer < LAYER_BITS'(MAX_LAYERS - 1)) begin
               w_we    = 1'b1;
               w_waddr = {req_weight_layer, req_source_index, req_dest_index};
            end
            if (req_take && req_kind == KIND_ACT && {1'b0, req_source_index} < w_in0) begin
               a_we    = 1'b1;
               vld_set = 1'b1;
            end
         end
         ST_ACC: begin
            if (d_last) begin
               d_in = '0;
               s_in = s_last ? '0 : s_ff + IDX_BITS'(1);
            end else begin
               d_in = d_ff + IDX_BITS'(1);
            end
         end
         ST_SQ: begin
            if (out_layer) begin
               rsp_load = 1'b1;
            end else begin
               a_we    = 1'b1;
               a_waddr = {l_ff + LAYER_BITS'(1), d_ff};
               a_wdata = sq_out;
               if (d_last) begin
                  acc_clear = 1'b1;
                  l_in      = l_ff + LAYER_BITS'(1);
                  s_in      = '0;
                  d_in      = '0;
               end else begin
                  d_in = d_ff + IDX_BITS'(1);
               end
            end
         end
         ST_OUT: begin
            if (rsp_take) begin
               if (d_last) vld_clear = 1'b1;
               else        d_in = d_ff + IDX_BITS'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         l_ff           <= '0;
         s_ff           <= '0;
         d_ff           <= '0;
         vld_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         layer_count_ff <= 3'd3;
         width_ff[0]    <= CFG_BITS'(16);
         width_ff[1]    <= CFG_BITS'(16);
         width_ff[2]    <= CFG_BITS'(16);
         width_ff[3]    <= CFG_BITS'(16);
         mode_ff        <= MODE_SIGMOID;
         sqin_ff        <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         l_ff     <= l_in;
         s_ff     <= s_in;
         d_ff     <= d_in;
         if (vld_clear)    vld_ff <= '0;
         else if (vld_set) vld_ff[req_source_index] <= 1'b1;
         if (rsp_load)      rsp_valid_ff <= 1'b1;
         else if (rsp_take) rsp_valid_ff <= 1'b0;
         if (csr_write) begin
            case (csr_index)
               CSR_LAYER_COUNT: layer_count_ff <= csr_data[2:0];
               CSR_WIDTH0:      width_ff[0]    <= csr_data;
               CSR_WIDTH1:      width_ff[1]    <= csr_data;
               CSR_WIDTH2:      width_ff[2]    <= csr_data;
               CSR_WIDTH3:      width_ff[3]    <= csr_data;
               CSR_ACT_MODE:    mode_ff        <= csr_data[0];
               CSR_SQUASH_IN:   sqin_ff        <= csr_data[0];
               default: begin
               end
            endcase
         end
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (w_we) wmem[w_waddr] <= w_wdata;
      w_q <= wmem[{l_ff, s_ff, d_ff}];
   end

   always_ff @(posedge clock) begin
      if (a_we) amem[a_waddr] <= a_wdata;
      a_q     <= amem[{l_ff, s_ff}];
      a_vld_q <= (l_ff != '0) || vld_ff[s_ff];
   end

   // arithmetic and result registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_SRC) begin
         src_ff <= (l_ff == '0 && sqin_ff) ? sq_out : src_raw;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= src_ff * w_q;
      end
      if (acc_clear) begin
         for (int i = 0; i < MAX_WIDTH; i++) acc_ff[i] <= '0;
      end else if (state_ff == ST_ACC) begin
         acc_ff[d_ff] <= sum_sat;
      end
      if (rsp_load) begin
         rsp_index_ff <= d_ff;
         rsp_value_ff <= sq_out;
         rsp_last_ff  <= d_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_output_index = rsp_index_ff;
   assign rsp_output_value = rsp_value_ff;
   assign rsp_output_last  = rsp_last_ff;

   a_no_beat_out_while_ready: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid)
      else $error("result beat pending while input is taken");

   a_src_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC) |-> ({1'b0, s_ff} < ws && {1'b0, d_ff} < wd))
      else $error("accumulate index out of layer range");

   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_output_last) |=> !req_stall)
      else $error("not ready after final result beat");

   a_index_in_output_layer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_output_index} < w_out))
      else $error("result index beyond output layer");

endmodule
`default_nettype wire
